// ===== sv/bpa_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the block pool allocator: commands, statuses
// and the fixed field widths.
// -----------------------------------------------------------------------------
package bpa_pkg;

    localparam int REQ_W  = 21;     // request_bytes width
    localparam int CFG_W  = 21;     // pool_bytes register width
    localparam int SIZE_W = REQ_W + 1;  // rounded request can reach 2^21
    localparam int STAT_W = 3;

    typedef logic [STAT_W-1:0] t_status;
    typedef logic              t_cmd;

    localparam t_cmd CMD_ALLOC = 1'b0;
    localparam t_cmd CMD_FREE  = 1'b1;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_NO_SPACE   = 3'd1;
    localparam t_status ST_TABLE_FULL = 3'd2;
    localparam t_status ST_NOT_FOUND  = 3'd3;
    localparam t_status ST_ZERO_SIZE  = 3'd4;

endpackage : bpa_pkg
`default_nettype wire

// ===== sv/bpa_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// bpa_if
// Valid/ready channels of the block pool allocator: request and response.
// -----------------------------------------------------------------------------
interface bpa_req_if #(
    parameter int ADDR_W = 20
);
    logic                    valid;
    logic                    ready;
    bpa_pkg::t_cmd           cmd;
    logic [bpa_pkg::REQ_W-1:0] request_bytes;
    logic [ADDR_W-1:0]       block_offset;

    modport source (output valid, output cmd, output request_bytes,
                    output block_offset, input ready);
    modport sink   (input valid, input cmd, input request_bytes,
                    input block_offset, output ready);
endinterface : bpa_req_if

interface bpa_rsp_if #(
    parameter int ADDR_W = 20
);
    logic              valid;
    logic              ready;
    bpa_pkg::t_status  status;
    logic [ADDR_W-1:0] result_offset;

    modport source (output valid, output status, output result_offset,
                    input ready);
    modport sink   (input valid, input status, input result_offset,
                    output ready);
endinterface : bpa_rsp_if
`default_nettype wire

// ===== sv/block_pool_allocator.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// block_pool_allocator
// Allocator over a byte pool kept as a table of block entries: an allocate takes the
// lowest-addressed exact fit, else splits the lowest-addressed larger free block.
// Usage:
//   i_req carries one command word: allocate (request_bytes, rounded up to a
//   multiple of 8) or free (block_offset). o_rsp returns one word per command
//   with a status and, for a successful allocate, the block's pool offset.
//   i_cfg_we/i_cfg_wdata write the pool size; a write re-initializes the
//   table to one free block covering the pool. Write it only while idle.
// Timing:
//   Every command except a zero-size allocate walks the whole entry table,
//   one entry per cycle through the table memory's single read port; when a
//   block is split, start/length go through the one write port twice. A
//   zero-size allocate skips the table walk. i_req.ready is high only
//   while idle.
// Reset: synchronous; the pool is 1048576 bytes (capped at 2^POOL_ADDR_BITS
//   bytes) with entry 0 free. No memory clearing pass is needed.
// Stall: the response sits in an output register; a new command is taken
//   while it waits, and that command's result holds until the slot frees up.
// -----------------------------------------------------------------------------
module block_pool_allocator #(
    parameter int MAX_BLOCKS     = 64,
    parameter int POOL_ADDR_BITS = 20
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [bpa_pkg::CFG_W-1:0] i_cfg_wdata,
    bpa_req_if.sink                        i_req,
    bpa_rsp_if.source                      o_rsp
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SW = POOL_ADDR_BITS;         // block start
    localparam int LW = POOL_ADDR_BITS + 1;     // block length
    localparam int CW = (LW > bpa_pkg::SIZE_W) ? LW : bpa_pkg::SIZE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_WSLOT = 3'd3;
    localparam logic [2:0] S_WBIG  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [MAX_BLOCKS-1:0] INIT_IN_USE = MAX_BLOCKS'(1);
    localparam logic [IW:0]           CNT_END     = (IW+1)'(MAX_BLOCKS);
    localparam logic [IW-1:0]         IDX_LAST    = IW'(MAX_BLOCKS - 1);

    function automatic logic [LW-1:0] clamp_pool(input logic [bpa_pkg::CFG_W-1:0] val);
        logic [33:0] v;
        logic [33:0] limit;
        v     = 34'(val);
        limit = 34'(1) << POOL_ADDR_BITS;
        if (v > limit) begin
            v = limit;
        end
        return LW'(v & ~34'd7);
    endfunction

    // control
    logic [2:0]            r_state, n_state;
    logic [MAX_BLOCKS-1:0] r_in_use;
    logic [MAX_BLOCKS-1:0] r_alloc;
    logic                  r_e0_fresh;  // entry 0 not yet written since init
    logic [LW-1:0]         r_pool;
    logic                  r_out_valid;
    logic [IW:0]           r_ri;        // read issue counter
    logic                  r_cv;        // compare stage valid
    logic [IW-1:0]         r_ci;        // compare stage index

    // payload
    bpa_pkg::t_cmd             r_cmd;
    logic [bpa_pkg::SIZE_W-1:0] r_size;
    logic [SW-1:0]             r_off;
    logic                      r_ex_found, r_bg_found, r_sl_found, r_fr_found;
    logic [IW-1:0]             r_ex_idx, r_bg_idx, r_sl_idx, r_fr_idx;
    logic [SW-1:0]             r_ex_start, r_bg_start;
    logic [LW-1:0]             r_bg_len;
    bpa_pkg::t_status          r_res_status, r_out_status;
    logic [SW-1:0]             r_res_off, r_out_off;

    // table memory
    logic [SW-1:0] mem_start [MAX_BLOCKS];
    logic [LW-1:0] mem_len   [MAX_BLOCKS];
    logic [SW-1:0] r_q_start;
    logic [LW-1:0] r_q_len;

    logic          req_fire, rsp_fire, out_load;
    logic          zero_req;
    logic          w_en;
    logic [IW-1:0] w_addr;
    logic [SW-1:0] w_start;
    logic [LW-1:0] w_len;
    logic [SW-1:0] c_start;
    logic [LW-1:0] c_len;
    logic [CW-1:0] c_len_x, size_x;
    logic          c_en, c_al, c_free;
    logic [bpa_pkg::SIZE_W-1:0] rounded;

    assign i_req.ready         = (r_state == S_IDLE);
    assign req_fire            = i_req.valid && (r_state == S_IDLE);
    assign rsp_fire            = r_out_valid && o_rsp.ready;
    assign out_load            = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.result_offset = r_out_off;

    assign zero_req = (i_req.cmd == bpa_pkg::CMD_ALLOC) && (i_req.request_bytes == '0);
    assign rounded  = (bpa_pkg::SIZE_W'(i_req.request_bytes) + bpa_pkg::SIZE_W'(7))
                      & ~bpa_pkg::SIZE_W'(7);

    // compare stage view of the entry; entry 0 reads its init value until written
    assign c_start = (r_ci == '0 && r_e0_fresh) ? '0     : r_q_start;
    assign c_len   = (r_ci == '0 && r_e0_fresh) ? r_pool : r_q_len;
    assign c_len_x = CW'(c_len);
    assign size_x  = CW'(r_size);
    assign c_en    = r_in_use[r_ci];
    assign c_al    = r_alloc[r_ci];
    assign c_free  = c_en && !c_al;

    // write port: new allocated front part, then the shrunken remainder
    always_comb begin
        w_en    = 1'b0;
        w_addr  = r_sl_idx;
        w_start = r_bg_start;
        w_len   = LW'(r_size);
        case (r_state)
            S_WSLOT: begin
                w_en = 1'b1;
            end
            S_WBIG: begin
                w_en    = 1'b1;
                w_addr  = r_bg_idx;
                w_start = SW'(CW'(r_bg_start) + size_x);
                w_len   = LW'(CW'(r_bg_len) - size_x);
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem_start[w_addr] <= w_start;
            mem_len[w_addr]   <= w_len;
        end
        r_q_start <= mem_start[r_ri[IW-1:0]];
        r_q_len   <= mem_len[r_ri[IW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = zero_req ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cv && r_ci == IDX_LAST) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_cmd == bpa_pkg::CMD_ALLOC && !r_ex_found && r_bg_found && r_sl_found) begin
                    n_state = S_WSLOT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WSLOT: n_state = S_WBIG;
            S_WBIG:  n_state = S_FIN;
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= INIT_IN_USE;
            r_alloc     <= '0;
            r_e0_fresh  <= 1'b1;
            r_pool      <= clamp_pool(bpa_pkg::CFG_W'(1048576));
            r_out_valid <= 1'b0;
            r_ri        <= '0;
            r_cv        <= 1'b0;
            r_ci        <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (rsp_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_ri <= '0;
                    r_cv <= 1'b0;
                end
                S_SCAN: begin
                    r_cv <= (r_ri < CNT_END);
                    r_ci <= r_ri[IW-1:0];
                    if (r_ri < CNT_END) begin
                        r_ri <= r_ri + 1'b1;
                    end
                end
                S_DEC: begin
                    if (r_cmd == bpa_pkg::CMD_FREE) begin
                        if (r_fr_found) begin
                            r_alloc[r_fr_idx] <= 1'b0;
                        end
                    end else if (r_ex_found) begin
                        r_alloc[r_ex_idx] <= 1'b1;
                    end
                end
                S_WSLOT: begin
                    r_in_use[r_sl_idx] <= 1'b1;
                    r_alloc[r_sl_idx]  <= 1'b1;
                end
                default: begin
                end
            endcase
            if (w_en && w_addr == '0) begin
                r_e0_fresh <= 1'b0;
            end
            if (i_cfg_we) begin
                r_pool     <= clamp_pool(i_cfg_wdata);
                r_in_use   <= INIT_IN_USE;
                r_alloc    <= '0;
                r_e0_fresh <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_cmd        <= i_req.cmd;
            r_size       <= rounded;
            r_off        <= i_req.block_offset;
            r_ex_found   <= 1'b0;
            r_bg_found   <= 1'b0;
            r_sl_found   <= 1'b0;
            r_fr_found   <= 1'b0;
            r_res_status <= bpa_pkg::ST_ZERO_SIZE;
            r_res_off    <= '0;
        end
        if (r_state == S_SCAN && r_cv) begin
            if (r_cmd == bpa_pkg::CMD_FREE) begin
                if (c_en && c_al && c_start == r_off && !r_fr_found) begin
                    r_fr_found <= 1'b1;
                    r_fr_idx   <= r_ci;
                end
            end else begin
                if (c_free && c_len_x == size_x && (!r_ex_found || c_start < r_ex_start)) begin
                    r_ex_found <= 1'b1;
                    r_ex_idx   <= r_ci;
                    r_ex_start <= c_start;
                end
                if (c_free && c_len_x > size_x && (!r_bg_found || c_start < r_bg_start)) begin
                    r_bg_found <= 1'b1;
                    r_bg_idx   <= r_ci;
                    r_bg_start <= c_start;
                    r_bg_len   <= c_len;
                end
                if (!c_en && !r_sl_found) begin
                    r_sl_found <= 1'b1;
                    r_sl_idx   <= r_ci;
                end
            end
        end
        if (r_state == S_DEC) begin
            if (r_cmd == bpa_pkg::CMD_FREE) begin
                r_res_status <= r_fr_found ? bpa_pkg::ST_OK : bpa_pkg::ST_NOT_FOUND;
                r_res_off    <= '0;
            end else if (r_ex_found) begin
                r_res_status <= bpa_pkg::ST_OK;
                r_res_off    <= r_ex_start;
            end else if (!r_bg_found) begin
                r_res_status <= bpa_pkg::ST_NO_SPACE;
                r_res_off    <= '0;
            end else if (!r_sl_found) begin
                r_res_status <= bpa_pkg::ST_TABLE_FULL;
                r_res_off    <= '0;
            end else begin
                r_res_status <= bpa_pkg::ST_OK;
                r_res_off    <= r_bg_start;
            end
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_off    <= r_res_off;
        end
    end

endmodule : block_pool_allocator
`default_nettype wire

// ===== sv/bpa_chk.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// bpa_chk
// Port-level checks for the block pool allocator, bound to block_pool_allocator.
// -----------------------------------------------------------------------------
module bpa_chk #(
    parameter int ADDR_W = 20
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_req_valid,
    input wire logic                    i_req_ready,
    input wire logic                    i_rsp_valid,
    input wire logic                    i_rsp_ready,
    input wire bpa_pkg::t_status        i_rsp_status,
    input wire logic [ADDR_W-1:0]       i_rsp_offset
);

    // a pending response word holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_offset))
        else $error("response word changed while stalled");

    // one command at a time: busy right after a command is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while a command is in progress");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_status <= bpa_pkg::ST_ZERO_SIZE)
        else $error("undefined status code");

    a_fail_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != bpa_pkg::ST_OK |-> i_rsp_offset == '0)
        else $error("nonzero offset on a failed command");

endmodule : bpa_chk

bind block_pool_allocator bpa_chk #(
    .ADDR_W (POOL_ADDR_BITS)
) u_bpa_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_offset (o_rsp.result_offset)
);
`default_nettype wire
